// ----- design/mp2d_pkg.sv -----
// mp2d_pkg: shared types and constants for the 2-d maxima block
// holds controller states, command/status structs and default sizes
// no dependencies
package mp2d_pkg;

  localparam int unsigned NumPointsDft = 16;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned PointW       = 2 * CoordW;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SETUP   = 7'b0000010,
    ST_SORT_RD = 7'b0000100,
    ST_SORT_WR = 7'b0001000,
    ST_SCAN_RD = 7'b0010000,
    ST_SCAN_EV = 7'b0100000,
    ST_FLUSH   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;        // store the input point
    logic sort_init;   // start the merge sort and the scan bookkeeping
    logic merge_step;  // write one merged element
    logic scan_rd;     // read port a follows the scan index
    logic scan_step;   // evaluate one sorted point
    logic flush;       // hand out the final pending point
  } cmd_t;

  typedef struct packed {
    logic single;      // set holds at most one point, no sort needed
    logic sort_done;   // this merge step writes the final element
    logic scan_done;   // this scan step handles the final point
  } sts_t;

endpackage

// ----- design/mp2d_ram.sv -----
// mp2d_ram: generic ram, one write port and two registered read ports
// no dependencies
module mp2d_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- design/mp2d_ctrl.sv -----
// mp2d_ctrl: sequencer for load, merge sort and scan
// depends on mp2d_pkg
module mp2d_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            set_last_i,
  input  mp2d_pkg::sts_t  sts_i,
  output mp2d_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  mp2d_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      mp2d_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (set_last_i) begin
            state_d = mp2d_pkg::ST_SETUP;
          end
        end
      end
      mp2d_pkg::ST_SETUP: begin
        cmd_o.sort_init = 1'b1;
        state_d = sts_i.single ? mp2d_pkg::ST_SCAN_RD : mp2d_pkg::ST_SORT_RD;
      end
      mp2d_pkg::ST_SORT_RD: begin
        state_d = mp2d_pkg::ST_SORT_WR;
      end
      mp2d_pkg::ST_SORT_WR: begin
        cmd_o.merge_step = 1'b1;
        state_d = sts_i.sort_done ? mp2d_pkg::ST_SCAN_RD : mp2d_pkg::ST_SORT_RD;
      end
      mp2d_pkg::ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = mp2d_pkg::ST_SCAN_EV;
      end
      mp2d_pkg::ST_SCAN_EV: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = mp2d_pkg::ST_FLUSH;
        end else begin
          state_d = mp2d_pkg::ST_SCAN_RD;
        end
      end
      mp2d_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d = mp2d_pkg::ST_IDLE;
      end
      default: begin
        state_d = mp2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mp2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != mp2d_pkg::ST_IDLE);

  // scan evaluation always follows its read cycle
  a_ev_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mp2d_pkg::ST_SCAN_EV) |-> ($past(state_q) == mp2d_pkg::ST_SCAN_RD))
    else $error("scan evaluate without read");

  // a merge write is always preceded by its read cycle
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mp2d_pkg::ST_SORT_WR) |-> ($past(state_q) == mp2d_pkg::ST_SORT_RD))
    else $error("merge write without read");

endmodule

// ----- design/mp2d_dpath.sv -----
// mp2d_dpath: point store banks, merge counters, scan and result registers
// depends on mp2d_pkg and mp2d_ram
module mp2d_dpath #(
  parameter int unsigned NumPoints = mp2d_pkg::NumPointsDft
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mp2d_pkg::cmd_t                     cmd_i,
  output mp2d_pkg::sts_t                     sts_o,
  input  logic signed [mp2d_pkg::CoordW-1:0] point_x_i,
  input  logic signed [mp2d_pkg::CoordW-1:0] point_y_i,
  output logic                               max_valid_o,
  output logic signed [mp2d_pkg::CoordW-1:0] max_x_o,
  output logic signed [mp2d_pkg::CoordW-1:0] max_y_o,
  output logic                               run_last_o,
  output logic                               overflowed_o
);

  localparam int unsigned AW = $clog2(NumPoints);
  localparam int unsigned CW = $clog2(NumPoints + 1);
  localparam int unsigned SW = CW + 2;
  localparam int unsigned PW = mp2d_pkg::PointW;
  localparam int unsigned DW = mp2d_pkg::CoordW;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          src_q, src_d;
  logic [SW-1:0] width_q, width_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [SW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] idx_q, idx_d;
  logic signed [DW-1:0] best_q, best_d;
  logic          pend_q, pend_d;
  logic [PW-1:0] pend_pt_q, pend_pt_d;
  logic          strobe_q, strobe_d;
  logic [PW-1:0] out_pt_q, out_pt_d;
  logic          out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  logic [SW-1:0] n_ext;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [PW-1:0] wdata, b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b, da, db;
  logic          we0, we1;
  logic signed [DW-1:0] xa, xb, ya;
  logic          take_a, run_end, pass_end, sort_end, emit;
  logic [SW-1:0] k_nx, lo_nx, w2, run_lo, run_w, run_mid, run_hi;

  assign n_ext = SW'(count_q);

  // bank selection: src_q holds the bank being read
  assign da = src_q ? b1_rd_a : b0_rd_a;
  assign db = src_q ? b1_rd_b : b0_rd_b;
  assign xa = da[PW-1:DW];
  assign xb = db[PW-1:DW];
  assign ya = da[DW-1:0];

  assign raddr_a = cmd_i.scan_rd ? idx_q[AW-1:0] : i_q[AW-1:0];
  assign raddr_b = j_q[AW-1:0];

  // merge decision, ties take the left run
  assign take_a   = (i_q < mid_q) && ((j_q >= hi_q) || (xa >= xb));
  assign k_nx     = k_q + SW'(1);
  assign run_end  = (k_nx == hi_q);
  assign w2       = width_q << 1;
  assign lo_nx    = lo_q + w2;
  assign pass_end = (lo_nx >= n_ext);
  assign sort_end = (w2 >= n_ext);

  // bounds of the next run to merge
  always_comb begin
    if (cmd_i.sort_init) begin
      run_lo = '0;
      run_w  = SW'(1);
    end else if (!pass_end) begin
      run_lo = lo_nx;
      run_w  = width_q;
    end else begin
      run_lo = '0;
      run_w  = w2;
    end
    run_mid = ((run_lo + run_w) < n_ext) ? (run_lo + run_w) : n_ext;
    run_hi  = ((run_lo + (run_w << 1)) < n_ext) ? (run_lo + (run_w << 1)) : n_ext;
  end

  // write port steering
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = k_q[AW-1:0];
    wdata = take_a ? da : db;
    if (cmd_i.load) begin
      we0   = (count_q < CW'(NumPoints));
      waddr = count_q[AW-1:0];
      wdata = {point_x_i, point_y_i};
    end else if (cmd_i.merge_step) begin
      we0 = src_q;
      we1 = !src_q;
    end
  end

  assign emit = !pend_q || (ya > best_q);

  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    src_d      = src_q;
    width_d    = width_q;
    lo_d       = lo_q;
    mid_d      = mid_q;
    hi_d       = hi_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    idx_d      = idx_q;
    best_d     = best_q;
    pend_d     = pend_q;
    pend_pt_d  = pend_pt_q;
    strobe_d   = 1'b0;
    out_pt_d   = out_pt_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;

    if (cmd_i.load) begin
      if (count_q < CW'(NumPoints)) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.sort_init) begin
      src_d   = 1'b0;
      width_d = SW'(1);
      lo_d    = '0;
      mid_d   = run_mid;
      hi_d    = run_hi;
      i_d     = '0;
      j_d     = run_mid;
      k_d     = '0;
      idx_d   = '0;
      pend_d  = 1'b0;
    end

    if (cmd_i.merge_step) begin
      if (!run_end) begin
        k_d = k_nx;
        if (take_a) begin
          i_d = i_q + SW'(1);
        end else begin
          j_d = j_q + SW'(1);
        end
      end else begin
        lo_d  = run_lo;
        mid_d = run_mid;
        hi_d  = run_hi;
        i_d   = run_lo;
        j_d   = run_mid;
        k_d   = run_lo;
        if (pass_end) begin
          width_d = w2;
          src_d   = !src_q;
        end
      end
    end

    if (cmd_i.scan_step) begin
      idx_d = idx_q + CW'(1);
      if (emit) begin
        best_d    = ya;
        pend_d    = 1'b1;
        pend_pt_d = da;
        if (pend_q) begin
          // an earlier point is now known not to be the last
          strobe_d   = 1'b1;
          out_pt_d   = pend_pt_q;
          out_last_d = 1'b0;
          out_ovf_d  = ovf_q;
        end
      end
    end

    if (cmd_i.flush) begin
      strobe_d   = 1'b1;
      out_pt_d   = pend_pt_q;
      out_last_d = 1'b1;
      out_ovf_d  = ovf_q;
      count_d    = '0;
      ovf_d      = 1'b0;
      pend_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      src_q    <= 1'b0;
      width_q  <= '0;
      lo_q     <= '0;
      mid_q    <= '0;
      hi_q     <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      best_q   <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      src_q    <= src_d;
      width_q  <= width_d;
      lo_q     <= lo_d;
      mid_q    <= mid_d;
      hi_q     <= hi_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
      best_q   <= best_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pt_q  <= pend_pt_d;
    out_pt_q   <= out_pt_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  mp2d_ram #(
    .Width (PW),
    .Depth (NumPoints)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (b0_rd_a),
    .rdata_b_o (b0_rd_b)
  );

  mp2d_ram #(
    .Width (PW),
    .Depth (NumPoints)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (b1_rd_a),
    .rdata_b_o (b1_rd_b)
  );

  assign sts_o.single    = (count_q <= CW'(1));
  assign sts_o.sort_done = run_end && pass_end && sort_end;
  assign sts_o.scan_done = ((idx_q + CW'(1)) == count_q);

  assign max_valid_o  = strobe_q;
  assign max_x_o      = out_pt_q[PW-1:DW];
  assign max_y_o      = out_pt_q[DW-1:0];
  assign run_last_o   = out_last_q;
  assign overflowed_o = out_ovf_q;

  a_merge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_step |-> (k_q < n_ext))
    else $error("merge write beyond the set");

  a_merge_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_step |-> ((i_q < mid_q) || (j_q < hi_q)))
    else $error("merge step with both runs exhausted");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NumPoints))
    else $error("point count above capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && out_last_q) |-> (count_q == '0) && !ovf_q && !pend_q)
    else $error("set state not cleared after final result");

endmodule

// ----- design/maximal_points_2d_unit.sv -----
// maximal_points_2d_unit: maxima of a 2-d point set, top level
// depends on mp2d_pkg, mp2d_ctrl, mp2d_dpath (which holds two mp2d_ram banks)
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   point    | in        | start_i & !busy_o     | point_x_i, point_y_i, set_last_i
//   maximum  | out       | max_valid_o (1 cycle) | max_x_o, max_y_o, run_last_o,
//            |           |                       | overflowed_o
//
// a point beat that is not last is stored while busy_o stays low
// the last beat starts the set work: a setup step, a merge sort over
// ceil(log2 n) passes, a scan of the sorted points and a flush, each merge
// or scan decision waiting on the registered ram read in front of it
// the receiver cannot stall; results leave as strobes during the scan, the
// final one in the cycle in which busy_o falls
// reset clears the count, overflow flag and sequencer; ram contents are kept
module maximal_points_2d_unit #(
  parameter int unsigned NumPoints = mp2d_pkg::NumPointsDft
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [mp2d_pkg::CoordW-1:0] point_x_i,
  input  logic signed [mp2d_pkg::CoordW-1:0] point_y_i,
  input  logic                               set_last_i,
  output logic                               max_valid_o,
  output logic signed [mp2d_pkg::CoordW-1:0] max_x_o,
  output logic signed [mp2d_pkg::CoordW-1:0] max_y_o,
  output logic                               run_last_o,
  output logic                               overflowed_o
);

  mp2d_pkg::cmd_t cmd;
  mp2d_pkg::sts_t sts;

  mp2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .set_last_i (set_last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  mp2d_dpath #(
    .NumPoints (NumPoints)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .max_valid_o  (max_valid_o),
    .max_x_o      (max_x_o),
    .max_y_o      (max_y_o),
    .run_last_o   (run_last_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// ----- tb/maximal_points_2d_unit_tb.sv -----
// maximal_points_2d_unit_tb: self-checking bench for the 2-d maxima block
// streams point sets through start_i/busy_o and checks every max_valid_o beat
// against a stable-sort-and-scan predictor; depends on mp2d_pkg and the rtl
`timescale 1ns / 100ps

module maximal_points_2d_unit_tb;

  localparam int unsigned NumPts = mp2d_pkg::NumPointsDft;
  localparam int unsigned CW     = mp2d_pkg::CoordW;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   run_last;
    logic   overflowed;
  } maximum_t;

  // keeps the points of the open set and the maxima still owed by the block
  class maxima_scoreboard;
    point_t   held[$];
    bit       dropped;
    maximum_t owed_maxima[$];
    int       errors;

    function void note_point(coord_t x, coord_t y, bit is_last);
      point_t   by_x[$];
      point_t   p;
      maximum_t m;
      bit       have_m;
      coord_t   best_y;
      int       k;
      p.x = x;
      p.y = y;
      if (held.size() < NumPts) held.push_back(p);
      else dropped = 1'b1;
      if (!is_last) return;
      // insertion behind every equal x keeps arrival order on ties
      foreach (held[i]) begin
        k = 0;
        while (k < by_x.size() && $signed(by_x[k].x) >= $signed(held[i].x)) k++;
        by_x.insert(k, held[i]);
      end
      have_m = 1'b0;
      best_y = '0;
      foreach (by_x[i]) begin
        if (!have_m || $signed(by_x[i].y) > $signed(best_y)) begin
          if (have_m) owed_maxima.push_back(m);
          best_y       = by_x[i].y;
          m.x          = by_x[i].x;
          m.y          = by_x[i].y;
          m.run_last   = 1'b0;
          m.overflowed = dropped;
          have_m       = 1'b1;
        end
      end
      m.run_last = 1'b1;
      owed_maxima.push_back(m);
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(coord_t x, coord_t y, logic rl, logic ov);
      maximum_t m;
      if (owed_maxima.size() == 0) begin
        $error("maximum beat with nothing owed: max_x=%0d max_y=%0d", x, y);
        errors++;
        return;
      end
      m = owed_maxima.pop_front();
      if (x !== m.x) begin
        $error("max_x: expected %0d, got %0d", m.x, x);
        errors++;
      end
      if (y !== m.y) begin
        $error("max_y: expected %0d, got %0d", m.y, y);
        errors++;
      end
      if (rl !== m.run_last) begin
        $error("run_last: expected %0b, got %0b", m.run_last, rl);
        errors++;
      end
      if (ov !== m.overflowed) begin
        $error("overflowed: expected %0b, got %0b", m.overflowed, ov);
        errors++;
      end
    endfunction

    function int pending();
      return owed_maxima.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  coord_t point_x_i;
  coord_t point_y_i;
  logic   set_last_i;
  logic   max_valid_o;
  coord_t max_x_o;
  coord_t max_y_o;
  logic   run_last_o;
  logic   overflowed_o;

  maxima_scoreboard sb;
  int               burst_left;
  int               points_sent;

  maximal_points_2d_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .set_last_i   (set_last_i),
    .max_valid_o  (max_valid_o),
    .max_x_o      (max_x_o),
    .max_y_o      (max_y_o),
    .run_last_o   (run_last_o),
    .overflowed_o (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // results first: a set's final beat may share an edge with the next set's last point
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (max_valid_o) sb.check_result(max_x_o, max_y_o, run_last_o, overflowed_o);
      if (start_i && !busy_o) sb.note_point(point_x_i, point_y_i, set_last_i);
    end
  end

  function automatic coord_t rand_coord(bit narrow);
    coord_t v;
    if (narrow) begin
      v = coord_t'($urandom_range(0, 6));
      return v - coord_t'(3);
    end
    v = coord_t'($urandom());
    return v;
  endfunction

  // sender works in bursts; a gap drops start and scrambles the payload
  task automatic send_point(coord_t x, coord_t y, bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 14);
      @(negedge clk_i);
      start_i    <= 1'b0;
      point_x_i  <= coord_t'($urandom());
      point_y_i  <= coord_t'($urandom());
      set_last_i <= 1'($urandom());
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    start_i    <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    set_last_i <= is_last;
    do @(posedge clk_i); while (busy_o);
    points_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0 || busy_o) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    int     set_size;
    int     pick;
    bit     narrow_x;
    bit     narrow_y;
    coord_t cx;
    coord_t cy;
    sb          = new();
    burst_left  = 0;
    points_sent = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    set_last_i  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // one-point set at the lowest corner
    send_point(-16'sd32768, -16'sd32768, 1'b1);
    // equal x: arrival order decides, equal-or-lower y is skipped
    send_point(16'sd5, 16'sd10, 1'b0);
    send_point(16'sd5, 16'sd30, 1'b0);
    send_point(16'sd5, 16'sd20, 1'b1);
    hold_until_drained();
    // full store, every point a maximum, then a closing point that is dropped
    for (int i = 0; i < NumPts; i++) begin
      cx = coord_t'(-32768 + i * 4369);
      cy = coord_t'(32767 - i * 4369);
      send_point(cx, cy, 1'b0);
    end
    send_point(16'sd32767, 16'sd32767, 1'b1);
    hold_until_drained();

    while (points_sent < 100) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) set_size = $urandom_range(NumPts + 1, NumPts + 4);
      else if (pick < 3) set_size = $urandom_range(1, 4);
      else set_size = $urandom_range(5, NumPts);
      narrow_x = 1'($urandom());
      narrow_y = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++)
        send_point(rand_coord(narrow_x), rand_coord(narrow_y), i == set_size - 1);
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("maximal_points_2d_unit_tb passed");
    end else begin
      $display("maximal_points_2d_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #3_600_000;
    $display("maximal_points_2d_unit_tb failed");
    $finish;
  end

endmodule
